// File: sv/skyap_pkg.sv
// Shared types and constants of the skyline atlas packer.
// Depends on nothing; imported by the sequencer and the top level.
`default_nettype none

package skyap_pkg;

  // Field widths of the request and result words
  localparam int FIELD_W = 12;
  // Width of page sizes and padded rectangle sides (values up to 8191)
  localparam int CW_W    = 13;
  // Width of the atlas_size register
  localparam int CFG_W   = 13;
  // APB data width
  localparam int APB_W   = 32;

  // One-pixel margin on each side of the bitmap
  localparam logic [CW_W-1:0] PAD = 13'd2;

  // Request codes
  localparam logic FUNC_PLACE = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  // Register word index (paddr[2])
  localparam logic REG_ATLAS_SIZE = 1'b0;

  // Reset value of atlas_size
  localparam logic [CFG_W-1:0] ATLAS_RESET = 13'd4096;

  // Result word
  typedef struct packed {
    logic               placed;
    logic [FIELD_W-1:0] left_col;
    logic [FIELD_W-1:0] top_row;
  } res_t;

endpackage

`default_nettype wire

// File: sv/skyline_atlas_packer.sv
// Top level of the skyline atlas packer: APB register, two RAMs and sequencer.
// Depends on skyap_pkg, skyap_ram and skyap_ctrl.
//
//  Channel   Direction  Handshake                 Word
//  request   in         start & !busy             func, glyph_width, glyph_height
//  result    out        done (one-cycle strobe)   placed, left_col, top_row
//  config    in/out     APB, pready tied high     atlas_size at byte address 0
//
// A place runs one pass of the heights RAM for block prefix maxima, one pass
// back for suffix maxima and window scores, a room check, then one write per
// raised column; with no room it answers after the room check.
// A place too wide for the page answers in the cycle after acceptance.
// A clear sweeps all MAX_ATLAS_SIZE heights, one per cycle, and answers once the
// sweep ends; reset runs the same sweep with busy high throughout.
// The receiver cannot stall results.
`default_nettype none

module skyline_atlas_packer #(
  parameter int MAX_ATLAS_SIZE = 4096
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic                           func,
  input  wire logic [skyap_pkg::FIELD_W-1:0]  glyph_width,
  input  wire logic [skyap_pkg::FIELD_W-1:0]  glyph_height,
  output logic                                done,
  output logic                                placed,
  output logic      [skyap_pkg::FIELD_W-1:0]  left_col,
  output logic      [skyap_pkg::FIELD_W-1:0]  top_row,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [2:0]                     paddr,
  input  wire logic [skyap_pkg::APB_W-1:0]    pwdata,
  output logic      [skyap_pkg::APB_W-1:0]    prdata,
  output logic                                pready
);

  import skyap_pkg::*;

  localparam int AW = $clog2(MAX_ATLAS_SIZE);
  localparam int HW = AW + 1;

  logic [CFG_W-1:0] atlas_size;
  res_t             res;
  logic             h_we;
  logic [AW-1:0]    h_addr;
  logic [HW-1:0]    h_wdata;
  logic [HW-1:0]    h_rdata;
  logic             p_we;
  logic [AW-1:0]    p_addr;
  logic [HW-1:0]    p_wdata;
  logic [HW-1:0]    p_rdata;
  logic             reg_hit;

  // Register decode; byte lanes within the word are ignored
  assign reg_hit = (paddr[2] == REG_ATLAS_SIZE) && (paddr[1:0] == paddr[1:0]);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? APB_W'(atlas_size) : '0;

  // Hold the page size
  always_ff @(posedge clk) begin
    if (rst) begin
      atlas_size <= ATLAS_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      atlas_size <= pwdata[CFG_W-1:0];
    end
  end

  // Result word onto its ports
  assign placed   = res.placed;
  assign left_col = res.left_col;
  assign top_row  = res.top_row;

  skyap_ram #(
    .DEPTH (MAX_ATLAS_SIZE),
    .DW    (HW)
  ) u_heights (
    .clk   (clk),
    .we    (h_we),
    .addr  (h_addr),
    .wdata (h_wdata),
    .rdata (h_rdata)
  );

  skyap_ram #(
    .DEPTH (MAX_ATLAS_SIZE),
    .DW    (HW)
  ) u_prefix (
    .clk   (clk),
    .we    (p_we),
    .addr  (p_addr),
    .wdata (p_wdata),
    .rdata (p_rdata)
  );

  skyap_ctrl #(
    .MAX_ATLAS_SIZE (MAX_ATLAS_SIZE),
    .AW             (AW),
    .HW             (HW)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .atlas_size   (atlas_size),
    .start        (start),
    .func         (func),
    .glyph_width  (glyph_width),
    .glyph_height (glyph_height),
    .busy         (busy),
    .done         (done),
    .res          (res),
    .h_we         (h_we),
    .h_addr       (h_addr),
    .h_wdata      (h_wdata),
    .h_rdata      (h_rdata),
    .p_we         (p_we),
    .p_addr       (p_addr),
    .p_wdata      (p_wdata),
    .p_rdata      (p_rdata)
  );

endmodule

`default_nettype wire

// File: sv/skyap_ram.sv
// Single-port synchronous RAM with registered read data.
// Depends on nothing; holds the skyline heights and the block-maximum scratch.
`default_nettype none

module skyap_ram #(
  parameter int DEPTH = 4096,
  parameter int DW    = 13
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [DW-1:0]            wdata,
  output logic      [DW-1:0]            rdata
);

  logic [DW-1:0] mem [DEPTH];

  // Read one entry per cycle and write it when we is high
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// File: sv/skyap_ctrl.sv
// Sequencer and datapath of the skyline packer: clearing sweep, prefix pass,
// suffix/window pass, room check and skyline raise. Uses skyap_pkg.
`default_nettype none

module skyap_ctrl #(
  parameter int MAX_ATLAS_SIZE = 4096,
  parameter int AW             = 12,
  parameter int HW             = 13
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic [skyap_pkg::CFG_W-1:0]    atlas_size,
  input  wire logic                           start,
  input  wire logic                           func,
  input  wire logic [skyap_pkg::FIELD_W-1:0]  glyph_width,
  input  wire logic [skyap_pkg::FIELD_W-1:0]  glyph_height,
  output logic                                busy,
  output logic                                done,
  output skyap_pkg::res_t                     res,
  output logic                                h_we,
  output logic      [AW-1:0]                  h_addr,
  output logic      [HW-1:0]                  h_wdata,
  input  wire logic [HW-1:0]                  h_rdata,
  output logic                                p_we,
  output logic      [AW-1:0]                  p_addr,
  output logic      [HW-1:0]                  p_wdata,
  input  wire logic [HW-1:0]                  p_rdata
);

  import skyap_pkg::*;

  localparam logic [CW_W-1:0] MAX_C      = CW_W'(MAX_ATLAS_SIZE);
  localparam logic [AW-1:0]   LAST_ENTRY = AW'(MAX_ATLAS_SIZE - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_UP,
    S_DOWN,
    S_CHECK,
    S_FILL
  } state_t;

  state_t            state;
  logic [CW_W-1:0]   cw;
  logic [CW_W-1:0]   ch;
  logic [CW_W-1:0]   size;
  logic [CW_W-1:0]   lim;
  logic [AW-1:0]     top_i;
  logic [AW-1:0]     idx;
  logic              iss;
  logic              rd_v;
  logic [AW-1:0]     rd_idx;
  logic              rd_ok;
  logic [CW_W-1:0]   k;
  logic [HW-1:0]     acc;
  logic              found;
  logic [AW-1:0]     best_x;
  logic [HW-1:0]     best_y;
  logic [HW-1:0]     nh;
  logic [AW-1:0]     cnt;
  logic              clr_res;

  logic [CW_W-1:0]   cw_in;
  logic [CW_W-1:0]   ch_in;
  logic [CW_W-1:0]   size_in;
  logic [CW_W-1:0]   cw_m1;
  logic [HW-1:0]     up_new;
  logic [HW-1:0]     s_new;
  logic [HW-1:0]     top_new;
  logic              better;
  logic [CW_W:0]     sum;

  function automatic logic [HW-1:0] hmax(input logic [HW-1:0] a, input logic [HW-1:0] b);
    hmax = (a > b) ? a : b;
  endfunction

  // Pad the request and clamp the page
  assign cw_in   = CW_W'(glyph_width) + PAD;
  assign ch_in   = CW_W'(glyph_height) + PAD;
  assign size_in = (atlas_size > MAX_C) ? MAX_C : atlas_size;
  assign cw_m1   = cw - CW_W'(1);

  // Prefix maximum within blocks of cw columns
  assign up_new  = (k == '0) ? h_rdata : hmax(h_rdata, acc);

  // Suffix maximum within blocks, window maximum and best pick
  assign s_new   = ((rd_idx == top_i) || (k == cw_m1)) ? h_rdata : hmax(h_rdata, acc);
  assign top_new = hmax(s_new, p_rdata);
  assign better  = !found || (top_new <= best_y);

  // Bottom edge of the reserved rectangle
  assign sum     = (CW_W+1)'(best_y) + (CW_W+1)'(ch);

  assign busy    = (state != S_IDLE);

  // Memory port steering
  always_comb begin
    h_we    = 1'b0;
    h_addr  = idx;
    h_wdata = nh;
    p_we    = 1'b0;
    p_addr  = rd_idx;
    p_wdata = up_new;
    unique case (state)
      S_CLEAR: begin
        h_we    = 1'b1;
        h_addr  = cnt;
        h_wdata = '0;
      end
      S_FILL: begin
        h_we    = 1'b1;
        h_addr  = best_x + cnt;
      end
      S_UP: begin
        p_we    = rd_v;
      end
      S_DOWN: begin
        p_addr  = AW'(CW_W'(idx) + cw_m1);
      end
      default: begin
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      cnt     <= '0;
      clr_res <= 1'b0;
      done    <= 1'b0;
      iss     <= 1'b0;
      rd_v    <= 1'b0;
      found   <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          if (cnt == LAST_ENTRY) begin
            state        <= S_IDLE;
            done         <= clr_res;
            res.placed   <= 1'b1;
            res.left_col <= '0;
            res.top_row  <= '0;
          end else begin
            cnt <= cnt + AW'(1);
          end
        end

        S_IDLE: begin
          if (start) begin
            if (func == FUNC_CLEAR) begin
              state   <= S_CLEAR;
              cnt     <= '0;
              clr_res <= 1'b1;
            end else if (cw_in > size_in) begin
              done         <= 1'b1;
              res.placed   <= 1'b0;
              res.left_col <= '0;
              res.top_row  <= '0;
            end else begin
              state <= S_UP;
              cw    <= cw_in;
              ch    <= ch_in;
              size  <= size_in;
              lim   <= size_in - cw_in;
              top_i <= AW'(size_in - CW_W'(1));
              idx   <= '0;
              iss   <= 1'b1;
              rd_v  <= 1'b0;
              k     <= '0;
              found <= 1'b0;
            end
          end
        end

        S_UP: begin
          // issue reads left to right
          if (iss) begin
            rd_v   <= 1'b1;
            rd_idx <= idx;
            if (idx == top_i) begin
              iss <= 1'b0;
            end else begin
              idx <= idx + AW'(1);
            end
          end else begin
            rd_v <= 1'b0;
          end
          // fold returned height into the block prefix
          if (rd_v) begin
            acc <= up_new;
            if (rd_idx == top_i) begin
              state <= S_DOWN;
              idx   <= top_i;
              iss   <= 1'b1;
            end else begin
              k <= (k == cw_m1) ? '0 : k + CW_W'(1);
            end
          end
        end

        S_DOWN: begin
          // issue reads right to left
          if (iss) begin
            rd_v   <= 1'b1;
            rd_idx <= idx;
            rd_ok  <= (CW_W'(idx) <= lim);
            if (idx == '0) begin
              iss <= 1'b0;
            end else begin
              idx <= idx - AW'(1);
            end
          end else begin
            rd_v <= 1'b0;
          end
          // fold into the block suffix and score the window
          if (rd_v) begin
            acc <= s_new;
            k   <= (k == '0) ? cw_m1 : k - CW_W'(1);
            if (rd_ok && better) begin
              found  <= 1'b1;
              best_x <= rd_idx;
              best_y <= top_new;
            end
            if (rd_idx == '0) begin
              state <= S_CHECK;
            end
          end
        end

        S_CHECK: begin
          if (found && (sum <= (CW_W+1)'(size))) begin
            state <= S_FILL;
            nh    <= HW'(sum);
            cnt   <= '0;
          end else begin
            state        <= S_IDLE;
            done         <= 1'b1;
            res.placed   <= 1'b0;
            res.left_col <= '0;
            res.top_row  <= '0;
          end
        end

        S_FILL: begin
          // raise the columns under the rectangle
          if (CW_W'(cnt) == cw_m1) begin
            state        <= S_IDLE;
            done         <= 1'b1;
            res.placed   <= 1'b1;
            res.left_col <= FIELD_W'(best_x);
            res.top_row  <= FIELD_W'(best_y);
          end else begin
            cnt <= cnt + AW'(1);
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking bench for skyline_atlas_packer: directed and random place and clear words,
// each result checked against a skyline kept in a small scoreboard class.
// Depends on skyap_pkg and the skyline_atlas_packer RTL.

module tb_top;
  import skyap_pkg::*;

  localparam int unsigned PAGE_COLS   = 4096;
  localparam int unsigned STALL_LIMIT = 60000;
  localparam int unsigned TAIL_CYCLES = 64;

  // Skyline of the page as it should stand, plus the spots still owed by the block
  class skyline_tracker;
    int unsigned     page_size;
    logic [CW_W-1:0] heights [PAGE_COLS];
    int unsigned     col_fifo [PAGE_COLS];
    res_t            pending_spots [$];
    int unsigned     mismatches;

    function new();
      page_size  = 32'(ATLAS_RESET);
      mismatches = 0;
      foreach (heights[i]) heights[i] = '0;
    endfunction

    // Sizes above the column count act as the column count
    function int unsigned usable_span();
      return (page_size > PAGE_COLS) ? PAGE_COLS : page_size;
    endfunction

    // Leftmost window with the lowest top edge, then raise it if it fits below the bottom
    function res_t place_rect(logic [FIELD_W-1:0] w, logic [FIELD_W-1:0] h);
      res_t        spot;
      int unsigned span, cw, ch, best_x, best_y, head, tail, x, top, i;
      spot   = '0;
      span   = usable_span();
      cw     = 32'(w) + 32'(PAD);
      ch     = 32'(h) + 32'(PAD);
      best_x = 0;
      best_y = 32'hFFFF_FFFF;
      head   = 0;
      tail   = 0;
      if (cw > span) return spot;
      // Slide a running maximum over every window of cw columns
      for (i = 0; i < span; i++) begin
        while (tail > head && heights[col_fifo[tail-1]] <= heights[i]) tail--;
        col_fifo[tail] = i;
        tail++;
        if (i + 1 >= cw) begin
          x = i + 1 - cw;
          while (col_fifo[head] < x) head++;
          top = 32'(heights[col_fifo[head]]);
          if (top < best_y) begin
            best_y = top;
            best_x = x;
          end
        end
      end
      if (best_y + ch > span) return spot;
      for (i = best_x; i < best_x + cw; i++) heights[i] = CW_W'(best_y + ch);
      spot.placed   = 1'b1;
      spot.left_col = best_x[FIELD_W-1:0];
      spot.top_row  = best_y[FIELD_W-1:0];
      return spot;
    endfunction

    // Work out the spot for an accepted word and queue it
    function void note_request(logic op, logic [FIELD_W-1:0] w, logic [FIELD_W-1:0] h);
      res_t spot;
      if (op == FUNC_CLEAR) begin
        foreach (heights[i]) heights[i] = '0;
        spot        = '0;
        spot.placed = 1'b1;
      end else begin
        spot = place_rect(w, h);
      end
      pending_spots.insert(pending_spots.size(), spot);
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    // Compare one result word with the oldest spot owed
    task check_spot(res_t got);
      res_t want;
      if (pending_spots.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: placed=%0d x=%0d y=%0d",
                                  got.placed, got.left_col, got.top_row));
        return;
      end
      want = pending_spots.pop_front();
      if (got.placed !== want.placed)
        report_mismatch($sformatf("placed got %0d want %0d", got.placed, want.placed));
      if (got.left_col !== want.left_col)
        report_mismatch($sformatf("left_col got %0d want %0d", got.left_col, want.left_col));
      if (got.top_row !== want.top_row)
        report_mismatch($sformatf("top_row got %0d want %0d", got.top_row, want.top_row));
    endtask
  endclass

  logic               clk          = 1'b0;
  logic               rst          = 1'b1;
  logic               start        = 1'b0;
  logic               func         = FUNC_PLACE;
  logic [FIELD_W-1:0] glyph_width  = '0;
  logic [FIELD_W-1:0] glyph_height = '0;
  logic               psel         = 1'b0;
  logic               penable      = 1'b0;
  logic               pwrite       = 1'b0;
  logic [2:0]         paddr        = '0;
  logic [APB_W-1:0]   pwdata       = '0;
  logic               busy;
  logic               done;
  logic               placed;
  logic [FIELD_W-1:0] left_col;
  logic [FIELD_W-1:0] top_row;
  logic [APB_W-1:0]   prdata;
  logic               pready;

  skyline_tracker tracker = new();
  bit             pacing_on = 1'b1;
  int unsigned    quiet_cycles = 0;

  skyline_atlas_packer #(
    .MAX_ATLAS_SIZE(PAGE_COLS)
  ) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .glyph_width(glyph_width), .glyph_height(glyph_height),
    .done(done), .placed(placed), .left_col(left_col), .top_row(top_row),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Check every result word at the edge that ends its strobe
  always @(posedge clk) begin
    if (!rst && done) tracker.check_spot(res_t'{placed, left_col, top_row});
  end

  // Abort when neither channel moves a word for too long
  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Present one request word, idling first at random; start stays high afterwards
  task automatic issue_request(input logic op, input int unsigned w, input int unsigned h);
    int unsigned gap;
    if (pacing_on && $urandom_range(99) < 12) begin
      if ($urandom_range(3) == 0) gap = $urandom_range(1, 3 * tracker.usable_span() + 64);
      else gap = $urandom_range(1, 4);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    func         <= op;
    glyph_width  <= w[FIELD_W-1:0];
    glyph_height <= h[FIELD_W-1:0];
    do @(posedge clk); while (busy);
    tracker.note_request(op, w[FIELD_W-1:0], h[FIELD_W-1:0]);
  endtask

  // Drop start and hold until every owed result is back and the block is free
  task automatic drain();
    start <= 1'b0;
    while (tracker.pending_spots.size() != 0 || busy) @(posedge clk);
  endtask

  // APB register write: setup phase, then access phase
  task automatic write_atlas_size(input int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_ATLAS_SIZE, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.page_size = value & 32'h1FFF;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // One page setting with random words: mostly small glyphs that fill the page
  task automatic run_phase(input int unsigned page, input int unsigned count);
    int unsigned lim;
    drain();
    write_atlas_size(page);
    lim = page / 8;
    repeat (count) begin
      if ($urandom_range(99) < 5)
        issue_request(FUNC_CLEAR, $urandom(), $urandom());
      else if ($urandom_range(99) < 10)
        issue_request(FUNC_PLACE, $urandom_range(4095), $urandom_range(4095));
      else
        issue_request(FUNC_PLACE, $urandom_range(lim), $urandom_range(lim));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Full page at reset size: exact fit, too wide, too tall, clear
    issue_request(FUNC_PLACE, 4094, 10);
    issue_request(FUNC_PLACE, 4095, 0);
    issue_request(FUNC_PLACE, 0, 0);
    issue_request(FUNC_PLACE, 0, 4094);
    issue_request(FUNC_CLEAR, 4095, 4095);
    issue_request(FUNC_PLACE, 0, 4094);
    issue_request(FUNC_PLACE, 4095, 4095);
    issue_request(FUNC_PLACE, 4094, 4094);
    issue_request(FUNC_PLACE, 1, 0);

    // Shrink the page over tall columns, then fill it exactly
    drain();
    write_atlas_size(256);
    issue_request(FUNC_PLACE, 254, 254);
    issue_request(FUNC_CLEAR, 0, 0);
    issue_request(FUNC_PLACE, 254, 254);
    issue_request(FUNC_PLACE, 0, 0);
    issue_request(FUNC_CLEAR, 0, 0);
    issue_request(FUNC_PLACE, 255, 0);

    // Oversized setting acts as the full column count
    drain();
    write_atlas_size(13'h1FFF);
    issue_request(FUNC_PLACE, 4094, 0);
    issue_request(FUNC_PLACE, 3000, 4093);

    // Degenerate pages leave no room at all
    drain();
    write_atlas_size(0);
    issue_request(FUNC_PLACE, 0, 0);
    drain();
    write_atlas_size(1);
    issue_request(FUNC_PLACE, 0, 0);

    // Random words over several page sizes; one phase runs with no idling
    run_phase(256, 18);
    run_phase(512, 18);
    pacing_on = 1'b0;
    run_phase(1000, 16);
    pacing_on = 1'b1;
    run_phase(256, 18);
    run_phase(2048, 12);
    run_phase(384, 14);
    run_phase(256, 16);
    run_phase(4096, 6);

    start <= 1'b0;
    while (tracker.pending_spots.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
